// ===== hw/rtl/wmab_pkg.sv =====
// ----------------------------------------------------------------------------
// wmab_pkg
// Shared sizes, derived widths and interface types for the weighted moving
// average bank.
// ----------------------------------------------------------------------------
package wmab_pkg;

   localparam int NUM_WINDOWS = 64;
   localparam int PRICE_BITS  = 24;

   localparam int SAMPLE_BITS = 24;
   localparam int LEN_BITS    = 7;
   localparam int AVG_BITS    = 32;
   localparam int FRAC_BITS   = 8;

   localparam int ADDR_BITS   = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
   localparam int WIN_BITS    = $clog2(NUM_WINDOWS + 1);
   localparam int DIV_BITS    = $clog2(NUM_WINDOWS * (NUM_WINDOWS + 1) / 2 + 1);
   localparam int PSUM_BITS   = PRICE_BITS + WIN_BITS;
   localparam int WSUM_BITS   = PRICE_BITS + DIV_BITS;
   localparam int QUOT_BITS   = PRICE_BITS + FRAC_BITS;
   localparam int STEP_BITS   = $clog2(QUOT_BITS);

   typedef struct packed {
      logic                  en;
      logic [ADDR_BITS-1:0]  addr;
      logic [PRICE_BITS-1:0] data;
   } hist_wr_type;

   typedef struct packed {
      logic                 start;
      logic [WSUM_BITS-1:0] wsum;
      logic [DIV_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [QUOT_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hw/rtl/weighted_moving_average_bank.sv =====
// ----------------------------------------------------------------------------
// weighted_moving_average_bank
// Keeps the newest NUM_WINDOWS price samples and, per sample, walks every
// window length emitting its linearly weighted moving average.
// Each window goes through the bit-serial divider, and a result stall holds
// the walk; req_stall is high whenever the bank is not idle, so a new sample
// is taken only after the last window result of the previous one is accepted.
// Reset: synchronous; history reads as zero at once through cleared valid bits.
// ----------------------------------------------------------------------------
module weighted_moving_average_bank (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [wmab_pkg::SAMPLE_BITS-1:0]  req_price_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [wmab_pkg::LEN_BITS-1:0]     rsp_window_length,
   output logic [wmab_pkg::AVG_BITS-1:0]     rsp_weighted_average,
   output logic                              rsp_last_window
);
   import wmab_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACC,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_BITS-1:0]  wptr_ff, wptr_in;
   logic [ADDR_BITS-1:0]  rptr_ff, rptr_in;
   logic [WIN_BITS-1:0]   win_ff, win_in;
   logic [PSUM_BITS-1:0]  psum_ff, psum_in;
   logic [WSUM_BITS-1:0]  wsum_ff, wsum_in;
   logic [DIV_BITS-1:0]   tri_ff, tri_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEN_BITS-1:0]   rsp_len_ff, rsp_len_in;
   logic [AVG_BITS-1:0]   rsp_avg_ff, rsp_avg_in;
   logic                  rsp_last_ff, rsp_last_in;

   hist_wr_type           hist_wr;
   div_req_type           div_req;
   div_rsp_type           div_rsp;
   logic [PRICE_BITS-1:0] rd_price;

   logic [PRICE_BITS+SAMPLE_BITS-1:0] sample_ext;
   logic [QUOT_BITS+AVG_BITS-1:0]     quot_ext;
   logic [WIN_BITS+LEN_BITS-1:0]      win_ext;
   logic [AVG_BITS-1:0]               avg_sat;

   wmab_hist_mem u_hist (
      .clock    (clock),
      .reset    (reset),
      .hist_wr  (hist_wr),
      .rd_addr  (rptr_ff),
      .rd_price (rd_price)
   );

   wmab_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // mask the sample to the stored price width
   assign sample_ext = {PRICE_BITS'(0), req_price_sample};

   always_comb begin
      hist_wr.en   = (state_ff == ST_IDLE) && req_valid;
      hist_wr.addr = wptr_ff;
      hist_wr.data = sample_ext[PRICE_BITS-1:0];
   end

   always_comb begin
      div_req.start   = (state_ff == ST_SUM);
      div_req.wsum    = wsum_ff + WSUM_BITS'(psum_ff);
      div_req.divisor = tri_ff;
   end

   // saturate the quotient to the result width
   always_comb begin
      quot_ext = {AVG_BITS'(0), div_rsp.quotient};
      if (|quot_ext[QUOT_BITS+AVG_BITS-1:AVG_BITS]) begin
         avg_sat = '1;
      end else begin
         avg_sat = quot_ext[AVG_BITS-1:0];
      end
      win_ext = {LEN_BITS'(0), win_ff};
   end

   always_comb begin
      state_in     = state_ff;
      wptr_in      = wptr_ff;
      rptr_in      = rptr_ff;
      win_in       = win_ff;
      psum_in      = psum_ff;
      wsum_in      = wsum_ff;
      tri_in       = tri_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rptr_in = wptr_ff;
               if (wptr_ff == ADDR_BITS'(NUM_WINDOWS - 1)) begin
                  wptr_in = '0;
               end else begin
                  wptr_in = wptr_ff + 1'b1;
               end
               win_in   = WIN_BITS'(1);
               psum_in  = '0;
               wsum_in  = '0;
               tri_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            psum_in  = psum_ff + PSUM_BITS'(rd_price);
            tri_in   = tri_ff + DIV_BITS'(win_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            wsum_in  = div_req.wsum;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = win_ext[LEN_BITS-1:0];
               rsp_avg_in   = avg_sat;
               rsp_last_in  = (win_ff == WIN_BITS'(NUM_WINDOWS));
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  win_in = win_ff + 1'b1;
                  if (rptr_ff == '0) begin
                     rptr_in = ADDR_BITS'(NUM_WINDOWS - 1);
                  end else begin
                     rptr_in = rptr_ff - 1'b1;
                  end
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rptr_ff     <= rptr_in;
      win_ff      <= win_in;
      psum_ff     <= psum_in;
      wsum_ff     <= wsum_in;
      tri_ff      <= tri_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_window_length    = rsp_len_ff;
   assign rsp_weighted_average = rsp_avg_ff;
   assign rsp_last_window      = rsp_last_ff;

endmodule

// ===== hw/rtl/wmab_hist_mem.sv =====
// ----------------------------------------------------------------------------
// wmab_hist_mem
// Circular price history with one write port, one registered read port and
// per-entry valid bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module wmab_hist_mem (
   input  logic                             clock,
   input  logic                             reset,
   input  wmab_pkg::hist_wr_type            hist_wr,
   input  logic [wmab_pkg::ADDR_BITS-1:0]   rd_addr,
   output logic [wmab_pkg::PRICE_BITS-1:0]  rd_price
);
   import wmab_pkg::*;

   logic [PRICE_BITS-1:0]  hist_ff [NUM_WINDOWS];
   logic [NUM_WINDOWS-1:0] valid_ff;
   logic [PRICE_BITS-1:0]  rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (hist_wr.en) begin
         hist_ff[hist_wr.addr] <= hist_wr.data;
      end
      rd_data_ff <= hist_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (hist_wr.en) begin
            valid_ff[hist_wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_price = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/wmab_divider.sv =====
// ----------------------------------------------------------------------------
// wmab_divider
// Restoring divider, one quotient bit per cycle. Divides the weighted sum
// scaled by the fraction bits by the window's weight total.
// ----------------------------------------------------------------------------
module wmab_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  wmab_pkg::div_req_type div_req,
   output wmab_pkg::div_rsp_type div_rsp
);
   import wmab_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [QUOT_BITS-1:0] dq_ff, dq_in;
   logic [DIV_BITS-1:0]  dvs_ff, dvs_in;
   logic [DIV_BITS:0]    trial;
   logic [DIV_BITS:0]    diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, dq_ff[QUOT_BITS-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = div_req.wsum[WSUM_BITS-1:PRICE_BITS];
         dq_in   = {div_req.wsum[PRICE_BITS-1:0], FRAC_BITS'(0)};
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         dq_in   = {dq_ff[QUOT_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dq_ff;

endmodule

// ===== hw/rtl/wmab_checker.sv =====
// ----------------------------------------------------------------------------
// wmab_checker
// Port-level checks of the weighted moving average bank, bound to the top.
// ----------------------------------------------------------------------------
module wmab_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [wmab_pkg::SAMPLE_BITS-1:0]  req_price_sample,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [wmab_pkg::LEN_BITS-1:0]     rsp_window_length,
   input logic [wmab_pkg::AVG_BITS-1:0]     rsp_weighted_average,
   input logic                              rsp_last_window
);
   import wmab_pkg::*;

   // no result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weighted_average)
         && $stable(rsp_window_length) && $stable(rsp_last_window))
      else $error("stalled result beat changed");

   // busy once a sample beat is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after sample beat");

   // no sample beat while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // more windows follow a result beat that is not the last
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_window |=> req_stall)
      else $error("input opened before the last window");

endmodule

bind weighted_moving_average_bank wmab_checker u_wmab_checker (.*);

// ===== tb/tb_weighted_moving_average_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_moving_average_bank
// Streams price samples into the averaging bank and checks every window
// result against a local copy of the price history and weighted sums.
// ----------------------------------------------------------------------------
module tb_weighted_moving_average_bank;
   import wmab_pkg::*;

   localparam int  CYCLE_LIMIT   = 5_000_000;
   localparam int  DIRECTED_N    = 16;
   localparam int  RANDOM_N      = 314;
   localparam int  QUIET_TAIL    = 30;
   localparam logic [SAMPLE_BITS-1:0] PRICE_MAX = {SAMPLE_BITS{1'b1}};

   typedef enum int {
      MODE_UNIFORM, MODE_MAX, MODE_ZERO, MODE_SMALL, MODE_SWING
   } price_mode_type;

   typedef struct {
      logic [LEN_BITS-1:0] len;
      logic [AVG_BITS-1:0] avg;
      logic                last_flag;
   } window_result_type;

   class wma_scoreboard;
      logic [PRICE_BITS-1:0] history [NUM_WINDOWS];
      window_result_type     averages_q [$];
      int                    errors;
      int                    samples;
      int                    checked;

      function new();
         foreach (history[i]) history[i] = '0;
         errors  = 0;
         samples = 0;
         checked = 0;
      endfunction

      function void note_sample(logic [SAMPLE_BITS-1:0] price);
         longint unsigned   plain_sum;
         longint unsigned   weighted_sum;
         longint unsigned   divisor;
         longint unsigned   avg;
         window_result_type r;
         plain_sum    = 0;
         weighted_sum = 0;
         for (int i = NUM_WINDOWS - 1; i > 0; i--) history[i] = history[i-1];
         history[0] = price[PRICE_BITS-1:0];
         for (int j = 1; j <= NUM_WINDOWS; j++) begin
            divisor      = (longint'(j) * longint'(j + 1)) / 2;
            plain_sum    += history[j-1];
            weighted_sum += plain_sum;
            avg = (weighted_sum << FRAC_BITS) / divisor;
            if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
            r.len       = j[LEN_BITS-1:0];
            r.avg       = avg[AVG_BITS-1:0];
            r.last_flag = (j == NUM_WINDOWS);
            averages_q.push_back(r);
         end
         samples++;
      endfunction

      function void report(string field, longint unsigned exp_v, longint unsigned act_v);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
         errors++;
      endfunction

      function void check_result(logic [LEN_BITS-1:0] len, logic [AVG_BITS-1:0] avg,
                                 logic last_flag);
         window_result_type e;
         if (averages_q.size() == 0) begin
            $display("%0t: unexpected window beat, expected none, actual len %0d avg %0h",
                     $time, len, avg);
            errors++;
            return;
         end
         e = averages_q.pop_front();
         checked++;
         if (len !== e.len) report("window_length", e.len, len);
         if (avg !== e.avg) report("weighted_average", e.avg, avg);
         if (last_flag !== e.last_flag) report("last_window", e.last_flag, last_flag);
      endfunction

      function int pending();
         return averages_q.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_price_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [LEN_BITS-1:0]       rsp_window_length;
   logic [AVG_BITS-1:0]       rsp_weighted_average;
   logic                      rsp_last_window;

   wma_scoreboard sb = new();
   bit            quiet = 1'b0;
   int            req_odds = 0;
   int            rsp_odds = 0;
   int            stall_left = 0;
   int            cycle_count = 0;

   weighted_moving_average_bank uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_price_sample     (req_price_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_window_length    (rsp_window_length),
      .rsp_weighted_average (rsp_weighted_average),
      .rsp_last_window      (rsp_last_window)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_weighted_moving_average_bank: errors");
         $finish;
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      bit next_stall;
      next_stall = 1'b0;
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_window_length, rsp_weighted_average, rsp_last_window);
      if (stall_left > 0) begin
         stall_left--;
         next_stall = !quiet;
      end else if (!reset && !quiet && rsp_odds > 0 && $urandom_range(rsp_odds - 1, 0) == 0) begin
         stall_left = $urandom_range(18, 0);
         next_stall = 1'b1;
      end
      rsp_stall <= next_stall;
   end

   task automatic send_price(logic [SAMPLE_BITS-1:0] price);
      if (!quiet && req_odds > 0 && $urandom_range(req_odds - 1, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_price_sample <= price;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_sample(price);
   endtask

   task automatic wait_drained();
      while (sb.pending() > 0) @(posedge clock);
   endtask

   task automatic pick_idling();
      case ($urandom_range(2, 0))
         0: begin
            req_odds = 0;
            rsp_odds = 0;
         end
         1: begin
            req_odds = 3;
            rsp_odds = 40;
         end
         default: begin
            req_odds = 2;
            rsp_odds = 4;
         end
      endcase
   endtask

   function automatic logic [SAMPLE_BITS-1:0] draw_price(price_mode_type mode);
      case (mode)
         MODE_MAX:   return PRICE_MAX;
         MODE_ZERO:  return '0;
         MODE_SMALL: return SAMPLE_BITS'($urandom_range(255, 0));
         MODE_SWING: return ($urandom_range(1, 0) == 1) ? PRICE_MAX : '0;
         default:    return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   initial begin
      logic [SAMPLE_BITS-1:0] directed [DIRECTED_N];
      price_mode_type         mode;
      int                     run_left;

      directed = '{
         24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000,
         24'h7FFFFF, 24'hAAAAAA, 24'h555555, 24'hFFFFFE,
         24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
         24'h0F0F0F, 24'hF0F0F0, 24'h000100, 24'h123456
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // early windows still see the reset zeros
      foreach (directed[i]) send_price(directed[i]);
      req_valid <= 1'b0;
      wait_drained();

      // a full window of maximum prices first, then mixed runs
      mode     = MODE_MAX;
      run_left = 66;
      pick_idling();
      for (int n = 0; n < RANDOM_N; n++) begin
         if (run_left == 0) begin
            mode     = price_mode_type'($urandom_range(4, 0));
            run_left = $urandom_range(80, 1);
            pick_idling();
         end
         if (n == RANDOM_N / 2) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         if (n >= RANDOM_N - QUIET_TAIL) quiet = 1'b1;
         send_price(draw_price(mode));
         run_left--;
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (80) @(posedge clock);

      if (sb.pending() != 0) begin
         $display("%0t: window results missing, expected %0d more, actual 0",
                  $time, sb.pending());
         sb.errors++;
      end
      $display("covered %0d price samples and %0d window averages, lengths 1 to %0d,",
               sb.samples, sb.checked, NUM_WINDOWS);
      $display("with zero-filled early history, full-scale windows and random back-pressure");
      if (sb.errors == 0) begin
         $display("tb_weighted_moving_average_bank: clean");
      end else begin
         $display("tb_weighted_moving_average_bank: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/wmab_pkg.sv
hw/rtl/wmab_hist_mem.sv
hw/rtl/wmab_divider.sv
hw/rtl/weighted_moving_average_bank.sv
hw/rtl/wmab_checker.sv
tb/tb_weighted_moving_average_bank.sv
